[src/sitda_pkg.sv]
package sitda_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DIGIT_BITS = 4;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_NINE  = 8'd57;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dabble_status_type;

endpackage

[src/sitda_dabble.sv]
module sitda_dabble #(
   parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF,
   parameter int NDIG = 10
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [VALUE_WIDTH-1:0]                        magnitude,
   output sitda_pkg::dabble_status_type                  status,
   output logic [NDIG-1:0][sitda_pkg::DIGIT_BITS-1:0]    bcd
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0]                     mag_ff, mag_in;
   logic [NDIG-1:0][sitda_pkg::DIGIT_BITS-1:0] bcd_ff, bcd_in;
   logic [NDIG-1:0][sitda_pkg::DIGIT_BITS-1:0] bcd_adj;
   logic [NDIG*sitda_pkg::DIGIT_BITS-1:0]      bcd_flat;
   logic [CNT_W-1:0]                           bit_cnt_ff, bit_cnt_in;
   logic                                       busy_ff, busy_in;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d] >= sitda_pkg::DIGIT_BITS'(5)) begin
            bcd_adj[d] = bcd_ff[d] + sitda_pkg::DIGIT_BITS'(3);
         end else begin
            bcd_adj[d] = bcd_ff[d];
         end
      end
   end

   assign bcd_flat = bcd_adj;

   always_comb begin
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      busy_in    = busy_ff;
      if (start) begin
         mag_in     = magnitude;
         bcd_in     = '0;
         bit_cnt_in = CNT_W'(VALUE_WIDTH);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in     = {bcd_flat[NDIG*sitda_pkg::DIGIT_BITS-2:0], mag_ff[VALUE_WIDTH-1]};
         bit_cnt_in = bit_cnt_ff - CNT_W'(1);
         busy_in    = (bit_cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         bit_cnt_ff <= bit_cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (bit_cnt_ff == CNT_W'(1));
   assign bcd         = bcd_ff;

endmodule

[src/signed_int_to_decimal_ascii_top.sv]
// flow: a value is taken only while idle, so a new one waits until its predecessor's last
// character is loaded; the bit-serial shift-add-3 converter takes one magnitude bit per
// cycle, then one character per cycle leaves the digit register while the output slot is
// free (a low rsp_ready holds it otherwise)
// reset: synchronous, active high; clears the sequencer, converter and output valid
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last
);

   localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam int IDX_W = $clog2(NDIG);

   sitda_pkg::state_type                        state_ff, state_in;
   sitda_pkg::dabble_status_type                dab_status;
   logic [NDIG-1:0][sitda_pkg::DIGIT_BITS-1:0]  bcd;

   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   accept;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       cnt_dec;
   logic [CNT_W-1:0]       size;
   logic [3:0]             digit;
   logic                   slot_free;
   logic                   load;
   logic [7:0]             load_char;
   logic                   load_last;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_character_ff;
   logic                   rsp_last_ff;

   assign accept    = req_valid && req_ready;
   assign magnitude = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cnt_dec   = cnt_ff - CNT_W'(1);
   assign digit     = bcd[cnt_dec[IDX_W-1:0]];

   sitda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NDIG        (NDIG)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (magnitude),
      .status    (dab_status),
      .bcd       (bcd)
   );

   // position of the top nonzero digit, at least one digit for zero
   always_comb begin
      size = CNT_W'(1);
      for (int d = 1; d < NDIG; d++) begin
         if (bcd[d] != '0) begin
            size = CNT_W'(d + 1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            if (req_valid) state_in = sitda_pkg::ST_CONVERT;
         end
         sitda_pkg::ST_CONVERT: begin
            if (dab_status.done) state_in = sitda_pkg::ST_SIZE;
         end
         sitda_pkg::ST_SIZE: begin
            state_in = sitda_pkg::ST_EMIT;
         end
         sitda_pkg::ST_EMIT: begin
            if (slot_free && !neg_ff && (cnt_ff == CNT_W'(1))) state_in = sitda_pkg::ST_IDLE;
         end
         default: state_in = sitda_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      load_char = sitda_pkg::ASCII_ZERO + {4'b0000, digit};
      load_last = 1'b0;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) neg_in = req_value[VALUE_WIDTH-1];
         end
         sitda_pkg::ST_CONVERT: begin
         end
         sitda_pkg::ST_SIZE: begin
            cnt_in = size;
         end
         sitda_pkg::ST_EMIT: begin
            if (slot_free) begin
               load = 1'b1;
               if (neg_ff) begin
                  load_char = sitda_pkg::ASCII_MINUS;
                  neg_in    = 1'b0;
               end else begin
                  load_last = (cnt_ff == CNT_W'(1));
                  cnt_in    = cnt_dec;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
      end
      if (load) begin
         rsp_character_ff <= load_char;
         rsp_last_ff      <= load_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == sitda_pkg::ST_EMIT |-> cnt_ff != '0 && cnt_ff <= CNT_W'(NDIG))
      else $error("digit count out of range while emitting");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> dab_status.busy)
      else $error("converter not busy after transfer");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      dab_status.done |-> state_ff == sitda_pkg::ST_CONVERT)
      else $error("conversion finished outside convert state");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      load && load_last |=> state_ff == sitda_pkg::ST_IDLE)
      else $error("sequencer not idle after last character");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_character == sitda_pkg::ASCII_MINUS
         || (rsp_character >= sitda_pkg::ASCII_ZERO && rsp_character <= sitda_pkg::ASCII_NINE))
      else $error("character is not a digit or minus sign");
`endif

endmodule
